// ----- design/hut_pkg.sv -----
package hut_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_STEPS = 16;

	localparam int ZFRAC = 16;
	localparam int PRESHIFT = 8;
	localparam int SAMPLE_W = 16;
	localparam int OFFSET_W = 13;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int XW = DIFF_W + PRESHIFT + 3;
	localparam int ZW = 27;
	localparam int HEAD_W = ANGLE_FRAC_BITS + 10;
	localparam int OUT_HEAD_W = 16;
	localparam int YAW_W = 32;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W = 5;

	localparam int HALF_TURN = 180 * (2 ** ANGLE_FRAC_BITS);
	localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int ROUND_HALF = 2 ** (ZFRAC - ANGLE_FRAC_BITS - 1);
	localparam int ROUND_SHIFT = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * (2 ** ZFRAC));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_FIN,
		ST_ACC,
		ST_HOLD
	} state_t;

	typedef enum logic {
		REG_OFFSET_X = 1'b0,
		REG_OFFSET_Y = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cordic_ctrl_t;

	function automatic logic signed [ZW-1:0] atan_tab(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0: v = ZW'(2949120);
			5'd1: v = ZW'(1740967);
			5'd2: v = ZW'(919879);
			5'd3: v = ZW'(466945);
			5'd4: v = ZW'(234379);
			5'd5: v = ZW'(117304);
			5'd6: v = ZW'(58666);
			5'd7: v = ZW'(29335);
			5'd8: v = ZW'(14668);
			5'd9: v = ZW'(7334);
			5'd10: v = ZW'(3667);
			5'd11: v = ZW'(1833);
			5'd12: v = ZW'(917);
			5'd13: v = ZW'(458);
			5'd14: v = ZW'(229);
			5'd15: v = ZW'(115);
			5'd16: v = ZW'(57);
			5'd17: v = ZW'(29);
			5'd18: v = ZW'(14);
			5'd19: v = ZW'(7);
			5'd20: v = ZW'(4);
			5'd21: v = ZW'(2);
			5'd22: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- design/heading_unwrap_tracker.sv -----
// Compass heading tracker. Each input word carries one magnetometer X/Y pair; the
// hard-iron offsets are subtracted at full width, and heading = -atan2(y, x) is
// formed in 1/128 degree by a vectoring CORDIC that runs one step per cycle on a
// single shared shift-add unit. op 1 only loads the reference heading; op 0 adds
// the unwrapped change from the previous heading to a saturating 32-bit yaw.
// A word accepted while idle passes through the PREP, ITER, FIN, ACC and HOLD states
// before its result is registered; in_stall stays high for that whole time and longer
// while the output register still holds an untaken result. Offsets may be written
// only while the block is idle.
module heading_unwrap_tracker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  hut_pkg::reg_idx_t                     cfg_index,
	input  logic [hut_pkg::OFFSET_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic signed [hut_pkg::SAMPLE_W-1:0]   x_sample,
	input  logic signed [hut_pkg::SAMPLE_W-1:0]   y_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [hut_pkg::OUT_HEAD_W-1:0] heading,
	output logic signed [hut_pkg::YAW_W-1:0]      total_yaw
);
	import hut_pkg::*;

	state_t state_q;
	state_t state_nx;

	logic signed [OFFSET_W-1:0] offset_x_q;
	logic signed [OFFSET_W-1:0] offset_y_q;
	logic signed [DIFF_W-1:0] x_q;
	logic signed [DIFF_W-1:0] y_q;
	logic op_q;
	logic out_valid_q;
	logic signed [OUT_HEAD_W-1:0] heading_q;
	logic signed [YAW_W-1:0] total_yaw_q;

	cordic_ctrl_t ctrl;
	logic last_step;
	logic signed [HEAD_W-1:0] cur_heading;
	logic signed [YAW_W-1:0] yaw;
	logic in_take;
	logic out_free;
	logic commit;

	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= 13'sd20;
			offset_y_q <= 13'sd387;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= DIFF_W'(x_sample) - DIFF_W'(offset_x_q);
			y_q <= DIFF_W'(y_sample) - DIFF_W'(offset_y_q);
			op_q <= op;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_PREP;
			ST_PREP: state_nx = ST_ITER;
			ST_ITER: if (last_step) state_nx = ST_FIN;
			ST_FIN: state_nx = ST_ACC;
			ST_ACC: state_nx = ST_HOLD;
			ST_HOLD: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		ctrl.load = (state_q == ST_PREP);
		ctrl.step = (state_q == ST_ITER);
		ctrl.finish = (state_q == ST_FIN);
		commit = (state_q == ST_ACC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	hut_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.x_in      (x_q),
		.y_in      (y_q),
		.last_step (last_step),
		.heading   (cur_heading)
	);

	hut_yaw u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.track     (!op_q),
		.heading   (cur_heading),
		.total_yaw (yaw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_HOLD && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			heading_q <= OUT_HEAD_W'(cur_heading);
			total_yaw_q <= yaw;
		end
	end

	assign out_valid = out_valid_q;
	assign heading = heading_q;
	assign total_yaw = total_yaw_q;

	a_result_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_HOLD))
		else $error("result raised outside the hold state");

	a_ref_keeps_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && op_q) |=> $stable(yaw))
		else $error("reference load changed the yaw");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> (cur_heading <= HEAD_W'(HALF_TURN)
			&& cur_heading >= -HEAD_W'(HALF_TURN)))
		else $error("heading outside half turn");

	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> $past(last_step))
		else $error("CORDIC finished early");

endmodule

// ----- design/hut_cordic.sv -----
module hut_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hut_pkg::cordic_ctrl_t               ctrl,
	input  logic signed [hut_pkg::DIFF_W-1:0]   x_in,
	input  logic signed [hut_pkg::DIFF_W-1:0]   y_in,
	output logic                                last_step,
	output logic signed [hut_pkg::HEAD_W-1:0]   heading
);
	import hut_pkg::*;

	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic [STEP_W-1:0] cnt_q;
	logic zero_q;
	logic signed [HEAD_W-1:0] heading_q;

	logic signed [XW-1:0] x_ext;
	logic signed [XW-1:0] y_ext;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] at;
	logic signed [ZW-1:0] z_rnd;
	logic signed [ZW-1:0] h_neg;
	logic signed [ZW-1:0] h_clamp;

	always_comb begin
		x_ext = XW'(x_in);
		y_ext = XW'(y_in);
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = atan_tab(ATAN_IDX_W'(cnt_q));
		z_rnd = (z_q + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;
		h_neg = -z_rnd;
		if (h_neg > ZW'(HALF_TURN))
			h_clamp = ZW'(HALF_TURN);
		else if (h_neg < -ZW'(HALF_TURN))
			h_clamp = -ZW'(HALF_TURN);
		else
			h_clamp = h_neg;
	end

	assign last_step = (cnt_q == STEP_W'(CORDIC_STEPS - 1));
	assign heading = heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			zero_q <= 1'b0;
		end else if (ctrl.load) begin
			cnt_q <= '0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (x_in < 0) begin
				x_q <= (-x_ext) <<< PRESHIFT;
				y_q <= (-y_ext) <<< PRESHIFT;
				z_q <= (y_in >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
			end else begin
				x_q <= x_ext <<< PRESHIFT;
				y_q <= y_ext <<< PRESHIFT;
				z_q <= '0;
			end
		end else if (ctrl.step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish)
			heading_q <= zero_q ? '0 : HEAD_W'(h_clamp);
	end

endmodule

// ----- design/hut_yaw.sv -----
module hut_yaw (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                commit,
	input  logic                                track,
	input  logic signed [hut_pkg::HEAD_W-1:0]   heading,
	output logic signed [hut_pkg::YAW_W-1:0]    total_yaw
);
	import hut_pkg::*;

	localparam int DW = HEAD_W + 2;
	localparam int SW = YAW_W + 2;

	logic signed [HEAD_W-1:0] prev_q;
	logic signed [YAW_W-1:0] acc_q;

	logic signed [DW-1:0] d_raw;
	logic signed [DW-1:0] d_unw;
	logic signed [SW-1:0] sum;
	logic signed [YAW_W-1:0] sat;

	always_comb begin
		d_raw = DW'(heading) - DW'(prev_q);
		if (d_raw < -DW'(HALF_TURN))
			d_unw = d_raw + DW'(FULL_TURN);
		else if (d_raw > DW'(HALF_TURN))
			d_unw = d_raw - DW'(FULL_TURN);
		else
			d_unw = d_raw;
		sum = SW'(acc_q) + SW'(d_unw);
		if (sum > SW'(32'sh7FFF_FFFF))
			sat = 32'sh7FFF_FFFF;
		else if (sum < SW'(32'sh8000_0000))
			sat = 32'sh8000_0000;
		else
			sat = YAW_W'(sum);
	end

	assign total_yaw = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q <= '0;
		end else if (commit) begin
			prev_q <= heading;
			if (track)
				acc_q <= sat;
		end
	end

endmodule
